/* hdl/weighted_vtime_accounting_unit_macros.svh */
// assertion macros for the weighted virtual-time accounting unit
// expects signals named clk and arst_n in the scope of each use
`ifndef WEIGHTED_VTIME_ACCOUNTING_UNIT_MACROS_SVH
`define WEIGHTED_VTIME_ACCOUNTING_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WVA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define WVA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/wva_pkg.sv */
// shared constants, types and the reciprocal weight table of the vtime unit
// no dependencies
`default_nettype none

package wva_pkg;

	localparam int VTIME_W   = 64;
	localparam int SLICE_W   = 32;
	localparam int PRIO_W    = 8;
	localparam int CPU_W     = 8;
	localparam int OP_W      = 2;
	localparam int WIDX_W    = 6;
	localparam int WEIGHT_W  = 27;
	localparam int HALF_W    = 32;

	localparam logic [PRIO_W-1:0]  PRIO_BASE    = 8'd100;
	localparam int                 WEIGHT_SHIFT = 20;
	localparam logic [SLICE_W-1:0] SLICE_RESET  = 32'd1000000;

	// event opcodes
	localparam logic [OP_W-1:0] OP_ENABLE  = 2'd0;
	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_RUNNING = 2'd2;
	localparam logic [OP_W-1:0] OP_STOP    = 2'd3;

	// depth and address width of the result fifo behind the pipeline
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	typedef logic [VTIME_W-1:0] vtime_t;

	typedef struct packed {
		vtime_t task_vtime_out;
		vtime_t global_vtime;
	} result_t;

	// (1024 << 20) / load weight of each nice level; nice 19 fills the tail
	function automatic logic [WEIGHT_W-1:0] inv_weight(input logic [WIDX_W-1:0] idx);
		logic [WEIGHT_W-1:0] w;
		case (idx)
			6'd0:    w = 27'd12097;
			6'd1:    w = 27'd14964;
			6'd2:    w = 27'd19009;
			6'd3:    w = 27'd23204;
			6'd4:    w = 27'd29587;
			6'd5:    w = 27'd36830;
			6'd6:    w = 27'd46174;
			6'd7:    w = 27'd57404;
			6'd8:    w = 27'd71827;
			6'd9:    w = 27'd90109;
			6'd10:   w = 27'd112457;
			6'd11:   w = 27'd140911;
			6'd12:   w = 27'd176023;
			6'd13:   w = 27'd218952;
			6'd14:   w = 27'd274895;
			6'd15:   w = 27'd344037;
			6'd16:   w = 27'd429324;
			6'd17:   w = 27'd539297;
			6'd18:   w = 27'd677012;
			6'd19:   w = 27'd840831;
			6'd20:   w = 27'd1048576;
			6'd21:   w = 27'd1309441;
			6'd22:   w = 27'd1639300;
			6'd23:   w = 27'd2041334;
			6'd24:   w = 27'd2538396;
			6'd25:   w = 27'd3205199;
			6'd26:   w = 27'd3947580;
			6'd27:   w = 27'd4994148;
			6'd28:   w = 27'd6242685;
			6'd29:   w = 27'd7837531;
			6'd30:   w = 27'd9761289;
			6'd31:   w = 27'd12341860;
			6'd32:   w = 27'd15339168;
			6'd33:   w = 27'd19173961;
			6'd34:   w = 27'd23860929;
			6'd35:   w = 27'd29826161;
			6'd36:   w = 27'd37025580;
			6'd37:   w = 27'd46684427;
			6'd38:   w = 27'd59652323;
			default: w = 27'd71582788;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hdl/wva_if.sv */
// valid/ready channel interfaces for scheduler events and accounting results
// depends on wva_pkg
`default_nettype none

interface wva_evt_if;
	import wva_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [VTIME_W-1:0]  task_vtime;
	logic [PRIO_W-1:0]   static_priority;
	logic [CPU_W-1:0]    cpu_id;
	logic [VTIME_W-1:0]  timestamp;

	modport source (output valid, opcode, task_vtime, static_priority, cpu_id, timestamp,
		input ready);
	modport sink (input valid, opcode, task_vtime, static_priority, cpu_id, timestamp,
		output ready);
endinterface

interface wva_res_if;
	import wva_pkg::*;

	logic                valid;
	logic                ready;
	logic [VTIME_W-1:0]  task_vtime_out;
	logic [VTIME_W-1:0]  global_vtime;

	modport source (output valid, task_vtime_out, global_vtime, input ready);
	modport sink (input valid, task_vtime_out, global_vtime, output ready);
endinterface

`default_nettype wire

/* hdl/weighted_vtime_accounting_unit.sv */
// beats pass stages s1 to s4, then the result fifo; throughput: one event per cycle
// while the fifo has room; run start times sit in one synchronous memory
// with one read and one write per cycle, the charge multiply is split in two halves
// an 8-entry result fifo with an in-flight count keeps input and output apart
// reset: global vtime to zero, slice_length to 1000000, all run start valid bits
// cleared at once so every CPU reads a start time of zero until it first runs
`default_nettype none

module weighted_vtime_accounting_unit #(
	parameter int CPU_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wva_pkg::SLICE_W-1:0]   cfg_wdata,
	wva_evt_if.sink                       evt,
	wva_res_if.source                     res
);
	import wva_pkg::*;

	`include "weighted_vtime_accounting_unit_macros.svh"

	// cpu numbers are only 8 bits wide, so at most 256 entries are reachable
	localparam int               MEM_DEPTH = (CPU_COUNT < 256) ? CPU_COUNT : 256;
	localparam int               ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam logic [CPU_W-1:0] CPU_MASK  = CPU_W'(CPU_COUNT - 1);

	// configuration and global state
	logic [SLICE_W-1:0] slice_q;
	vtime_t             cur_vtime_q;

	// run start store
	vtime_t             start_mem [MEM_DEPTH];
	logic               start_vld_q [MEM_DEPTH];

	// in-flight accounting and result fifo
	logic [FIFO_AW:0]   cnt_q;
	logic [FIFO_AW:0]   wr_ptr_q;
	logic [FIFO_AW:0]   rd_ptr_q;
	result_t            fifo_q [FIFO_DEPTH];

	logic               acc;
	logic               pop;
	logic [CPU_W-1:0]   slot_full;
	logic [ADDR_W-1:0]  slot;
	vtime_t             run_diff;
	vtime_t             cur_next;

	// stage 1: memory read data
	logic               v_s1;
	logic [OP_W-1:0]    op_s1;
	vtime_t             tv_s1;
	vtime_t             ts_s1;
	vtime_t             cur_s1;
	logic [PRIO_W-1:0]  prio_s1;
	vtime_t             start_rd_s1;
	logic               start_vld_s1;

	// stage 2: elapsed time and enqueue bound
	logic               v_s2;
	logic [OP_W-1:0]    op_s2;
	vtime_t             tv_s2;
	vtime_t             cur_s2;
	vtime_t             used_s2;
	vtime_t             bound_s2;
	logic [WEIGHT_W-1:0] wt_s2;

	// stage 3: partial products and queue key
	logic               v_s3;
	logic [OP_W-1:0]    op_s3;
	vtime_t             tv_s3;
	vtime_t             cur_s3;
	logic [HALF_W+WEIGHT_W-1:0] plo_s3;
	logic [HALF_W-1:0]  phi_s3;
	vtime_t             key_s3;

	// stage 4: scaled charge
	logic               v_s4;
	logic [OP_W-1:0]    op_s4;
	vtime_t             tv_s4;
	vtime_t             cur_s4;
	logic [VTIME_W-WEIGHT_SHIFT-1:0] scaled_s4;
	vtime_t             key_s4;

	vtime_t             start_val;
	vtime_t             used;
	vtime_t             bound;
	logic [WIDX_W-1:0]  widx;
	logic [HALF_W+WEIGHT_W-1:0] plo;
	logic [HALF_W+WEIGHT_W-1:0] phi_full;
	vtime_t             key;
	vtime_t             prod;
	vtime_t             result;

	// handshake: room for every beat in flight in the fifo
	assign evt.ready = (cnt_q < (FIFO_AW+1)'(FIFO_DEPTH));
	assign acc       = evt.valid && evt.ready;
	assign res.valid = (rd_ptr_q != wr_ptr_q);
	assign pop       = res.valid && res.ready;

	assign slot_full = evt.cpu_id & CPU_MASK;
	assign slot      = slot_full[ADDR_W-1:0];

	// running: global vtime moves up to the task vtime when it is later
	assign run_diff = cur_vtime_q - evt.task_vtime;
	assign cur_next = run_diff[VTIME_W-1] ? evt.task_vtime : cur_vtime_q;

	// slice register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SLICE_RESET;
		end else if (cfg_we) begin
			slice_q <= cfg_wdata;
		end
	end

	// global virtual time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vtime_q <= '0;
		end else if (acc && evt.opcode == OP_RUNNING) begin
			cur_vtime_q <= cur_next;
		end
	end

	// run start memory: written on running, read on every beat
	always_ff @(posedge clk) begin
		if (acc && evt.opcode == OP_RUNNING) begin
			start_mem[slot] <= evt.timestamp;
		end
		if (acc) begin
			start_rd_s1 <= start_mem[slot];
		end
	end

	// per-entry valid bits stand in for clearing the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEM_DEPTH; i++) begin
				start_vld_q[i] <= 1'b0;
			end
		end else if (acc && evt.opcode == OP_RUNNING) begin
			start_vld_q[slot] <= 1'b1;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1 payload, cur carries the value after this beat
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1        <= evt.opcode;
			tv_s1        <= evt.task_vtime;
			ts_s1        <= evt.timestamp;
			prio_s1      <= evt.static_priority;
			start_vld_s1 <= start_vld_q[slot];
			cur_s1       <= (evt.opcode == OP_RUNNING) ? cur_next : cur_vtime_q;
		end
	end

	// stage 1 logic: elapsed time, lagged bound, weight lookup
	assign start_val = start_vld_s1 ? start_rd_s1 : '0;
	assign used      = ts_s1 - start_val;
	assign bound     = cur_s1 - VTIME_W'(slice_q);
	assign widx      = WIDX_W'(prio_s1 - PRIO_BASE);

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		tv_s2    <= tv_s1;
		cur_s2   <= cur_s1;
		used_s2  <= used;
		bound_s2 <= bound;
		wt_s2    <= inv_weight(widx);
	end

	// stage 2 logic: two half-width products, queue key
	assign plo      = used_s2[HALF_W-1:0] * wt_s2;
	assign phi_full = used_s2[VTIME_W-1:HALF_W] * wt_s2;
	assign key      = (tv_s2 - bound_s2) >> (VTIME_W-1) != '0 ? bound_s2 : tv_s2;

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		tv_s3  <= tv_s2;
		cur_s3 <= cur_s2;
		plo_s3 <= plo;
		phi_s3 <= phi_full[HALF_W-1:0];
		key_s3 <= key;
	end

	// stage 3 logic: wrapped 64-bit product, then scale down
	assign prod = {phi_s3, {HALF_W{1'b0}}} + VTIME_W'(plo_s3);

	always_ff @(posedge clk) begin
		op_s4     <= op_s3;
		tv_s4     <= tv_s3;
		cur_s4    <= cur_s3;
		scaled_s4 <= prod[VTIME_W-1:WEIGHT_SHIFT];
		key_s4    <= key_s3;
	end

	// stage 4 logic: pick the result for the opcode
	always_comb begin
		case (op_s4)
			OP_ENABLE:  result = cur_s4;
			OP_ENQUEUE: result = key_s4;
			OP_RUNNING: result = tv_s4;
			OP_STOP:    result = tv_s4 + VTIME_W'(scaled_s4);
			default:    result = tv_s4;
		endcase
	end

	// result fifo storage
	always_ff @(posedge clk) begin
		if (v_s4) begin
			fifo_q[wr_ptr_q[FIFO_AW-1:0]] <= '{task_vtime_out: result, global_vtime: cur_s4};
		end
	end

	// fifo pointers and in-flight count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s4) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({acc, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// output beat from the fifo head
	assign res.task_vtime_out = fifo_q[rd_ptr_q[FIFO_AW-1:0]].task_vtime_out;
	assign res.global_vtime   = fifo_q[rd_ptr_q[FIFO_AW-1:0]].global_vtime;

	// checks
	`WVA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "in-flight count overflow")
	`WVA_ASSERT_NOW(a_fill_le_cnt, 1'b1, (wr_ptr_q - rd_ptr_q) <= cnt_q, "fifo holds more than in flight")
	`WVA_ASSERT_NOW(a_no_push_full, v_s4, (wr_ptr_q - rd_ptr_q) != (FIFO_AW+1)'(FIFO_DEPTH), "push into full fifo")
	`WVA_ASSERT_NEXT(a_run_sets_vld, acc && evt.opcode == OP_RUNNING, start_vld_q[$past(slot)], "run start not marked valid")

endmodule

`default_nettype wire
